FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes of the double-ended queue: command and status
// codes, field widths and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int CMD_W    = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                wr_front;
      logic                wr_rear;
      logic                rd_front;
      logic                rd_rear;
      logic                rd_dump;
      logic                dump_next;
      logic                dump_clear;
      logic                load_data;
      logic                data_last;
      logic                load_status;
      logic [STATUS_W-1:0] status;
   } ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic out_free;
      logic dump_end;
   } sts_type;

endpackage

FILE: rtl/deq_req_if.sv
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel of the double-ended queue: valid/ready with command and
// push value.
// ----------------------------------------------------------------------------
interface deq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [deq_pkg::CMD_W-1:0]            cmd;
   logic signed [deq_pkg::DATA_W-1:0]    value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

FILE: rtl/deq_rsp_if.sv
// ----------------------------------------------------------------------------
// deq_rsp_if
// Response channel of the double-ended queue: valid/ready with status,
// item and last flag.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [deq_pkg::STATUS_W-1:0]         status;
   logic signed [deq_pkg::DATA_W-1:0]    item;
   logic                                 last;

   modport source (output valid, output status, output item, output last, input ready);
   modport sink   (input valid, input status, input item, input last, output ready);
endinterface

FILE: rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller of the double-ended queue: decodes requests, sequences pop
// reads and dump streaming, and commands the datapath.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [deq_pkg::CMD_W-1:0] req_cmd,
   input  deq_pkg::sts_type          sts,
   output logic                      req_ready,
   output deq_pkg::ctl_type          ctl
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_POP   = 4'b0010,
      S_DREAD = 4'b0100,
      S_DOUT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_comb begin
      ctl       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE) && sts.out_free;
      accept    = req_valid && req_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd) inside
                  deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_REAR: begin
                     ctl.load_status = 1'b1;
                     if (sts.full) begin
                        ctl.status = deq_pkg::ST_FULL;
                     end else begin
                        ctl.status   = deq_pkg::ST_OK;
                        ctl.wr_front = (req_cmd == deq_pkg::CMD_PUSH_FRONT);
                        ctl.wr_rear  = (req_cmd == deq_pkg::CMD_PUSH_REAR);
                     end
                  end
                  deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_REAR: begin
                     if (sts.empty) begin
                        ctl.load_status = 1'b1;
                        ctl.status      = deq_pkg::ST_EMPTY;
                     end else begin
                        ctl.rd_front = (req_cmd == deq_pkg::CMD_POP_FRONT);
                        ctl.rd_rear  = (req_cmd == deq_pkg::CMD_POP_REAR);
                        state_in     = S_POP;
                     end
                  end
                  deq_pkg::CMD_DUMP: begin
                     if (sts.empty) begin
                        ctl.load_status = 1'b1;
                        ctl.status      = deq_pkg::ST_EMPTY;
                     end else begin
                        ctl.rd_dump = 1'b1;
                        state_in    = S_DOUT;
                     end
                  end
                  default: begin
                     // drop unused codes
                  end
               endcase
            end
         end
         S_POP: begin
            if (sts.out_free) begin
               ctl.load_data = 1'b1;
               ctl.data_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DREAD: begin
            ctl.rd_dump = 1'b1;
            state_in    = S_DOUT;
         end
         S_DOUT: begin
            if (sts.out_free) begin
               ctl.load_data = 1'b1;
               ctl.data_last = sts.dump_end;
               if (sts.dump_end) begin
                  ctl.dump_clear = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  ctl.dump_next = 1'b1;
                  state_in      = S_DREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Datapath of the double-ended queue: ring store, front index, fill count,
// dump offset and the response register.
// ----------------------------------------------------------------------------
module deq_dp #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  deq_pkg::ctl_type                    ctl,
   input  logic signed [deq_pkg::DATA_W-1:0]   req_value,
   input  logic                                rsp_ready,
   output deq_pkg::sts_type                    sts,
   output logic                                rsp_valid,
   output logic [deq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [deq_pkg::DATA_W-1:0]   rsp_item,
   output logic                                rsp_last
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0]   DEPTH_S = (IW+1)'(DEPTH);
   localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] k_ff, k_in;

   logic                              out_valid_ff, out_valid_in;
   logic [deq_pkg::STATUS_W-1:0]      out_status_ff, out_status_in;
   logic [deq_pkg::DATA_W-1:0]        out_item_ff, out_item_in;
   logic                              out_last_ff, out_last_in;

   logic [IW-1:0] offset;
   logic [IW:0]   sum;
   logic [IW-1:0] slot;
   logic [IW-1:0] front_dec;
   logic [IW-1:0] front_inc;
   logic [CW-1:0] count_dec;
   logic          wr_en;
   logic          rd_en;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] rd_addr;
   logic [deq_pkg::DATA_W-1:0] rd_data;

   assign count_dec = count_ff - 1'b1;

   always_comb begin
      if (ctl.wr_rear) begin
         offset = count_ff[IW-1:0];
      end else if (ctl.rd_rear) begin
         offset = count_dec[IW-1:0];
      end else begin
         offset = k_ff;
      end
      sum = {1'b0, front_ff} + {1'b0, offset};
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      slot = sum[IW-1:0];
   end

   assign front_dec = (front_ff == '0) ? LAST_IX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IX) ? '0 : front_ff + 1'b1;

   assign wr_en   = ctl.wr_front || ctl.wr_rear;
   assign wr_addr = ctl.wr_front ? front_dec : slot;
   assign rd_en   = ctl.rd_front || ctl.rd_rear || ctl.rd_dump;
   assign rd_addr = ctl.rd_front ? front_ff : slot;

   deq_ram #(
      .WIDTH (deq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      k_in     = k_ff;
      if (ctl.wr_front) begin
         front_in = front_dec;
         count_in = count_ff + 1'b1;
      end
      if (ctl.wr_rear) begin
         count_in = count_ff + 1'b1;
      end
      if (ctl.rd_front) begin
         front_in = front_inc;
         count_in = count_dec;
      end
      if (ctl.rd_rear) begin
         count_in = count_dec;
      end
      if (ctl.dump_next) begin
         k_in = k_ff + 1'b1;
      end
      if (ctl.dump_clear) begin
         k_in = '0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_item_in   = out_item_ff;
      out_last_in   = out_last_ff;
      if (ctl.load_status) begin
         out_valid_in  = 1'b1;
         out_status_in = ctl.status;
         out_item_in   = '0;
         out_last_in   = 1'b1;
      end else if (ctl.load_data) begin
         out_valid_in  = 1'b1;
         out_status_in = deq_pkg::ST_OK;
         out_item_in   = rd_data;
         out_last_in   = ctl.data_last;
      end else if (rsp_ready) begin
         out_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_item_ff   <= out_item_in;
      out_last_ff   <= out_last_in;
   end

   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == DEPTH_C);
   assign sts.out_free = !out_valid_ff || rsp_ready;
   assign sts.dump_end = (k_ff == count_dec[IW-1:0]);

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_item   = out_item_ff;
   assign rsp_last   = out_last_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (ctl.load_data || ctl.load_status) |-> (!out_valid_ff || rsp_ready))
      else $error("response register overwritten while held");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_front || ctl.wr_rear) |-> (count_ff != DEPTH_C))
      else $error("push into full store");

   a_pop_fill: assert property (@(posedge clock) disable iff (reset)
      (ctl.rd_front || ctl.rd_rear || ctl.rd_dump) |-> (count_ff != '0))
      else $error("read from empty store");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_front || ctl.wr_rear) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fill count not advanced by push");

endmodule

FILE: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Push: response registered in the cycle after the request is taken, one
// per cycle while responses are taken. Pop: the response passes the store
// read register, then the response register; the next request waits for
// it. Dump: each element passes the store read port, then the response
// register. Reset is synchronous: it empties the queue and clears the
// response valid flag; store contents are left as is, no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req_ch,
   deq_rsp_if.source  rsp_ch
);

   deq_pkg::ctl_type ctl;
   deq_pkg::sts_type sts;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .sts       (sts),
      .req_ready (req_ch.ready),
      .ctl       (ctl)
   );

   deq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .req_value  (req_ch.value),
      .rsp_ready  (rsp_ch.ready),
      .sts        (sts),
      .rsp_valid  (rsp_ch.valid),
      .rsp_status (rsp_ch.status),
      .rsp_item   (rsp_ch.item),
      .rsp_last   (rsp_ch.last)
   );

endmodule
